[rtl/pid_motor_drive_core_assert.svh]
// Assertion macros for the PID motor drive core, clocked on aclk, idle in reset
`ifndef PID_MOTOR_DRIVE_CORE_ASSERT_SVH
`define PID_MOTOR_DRIVE_CORE_ASSERT_SVH

// same-cycle implication
`define PMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define PMD_ASSERT_LATER(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> ##1 (cons)) \
        else $error(msg);

`endif

[rtl/pmd_pkg.sv]
// Shared types and constants of the PID motor drive core
`default_nettype none

package pmd_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned LIMIT_W = 15;
    localparam int unsigned INTEG_W = 24;
    localparam int unsigned PROD_W  = 33;
    localparam int unsigned ADDR_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RESET = LIMIT_W'(255);

    localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [2:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [2:0] REG_LIMIT_HIGH = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0]  gain_prop;
        logic [DATA_W-1:0]  gain_integ;
        logic [DATA_W-1:0]  gain_deriv;
        logic [DATA_W-1:0]  limit_low;
        logic [LIMIT_W-1:0] limit_high;
    } cfg_t;

    typedef struct packed {
        logic [INTEG_W-1:0] integ;
        logic [PROD_W-1:0]  prop_term;
        logic [PROD_W-1:0]  deriv_term;
    } stage_t;

endpackage

`default_nettype wire

[rtl/pmd_cfg_regs.sv]
// APB register file holding gains and limits
`default_nettype none

module pmd_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pmd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output pmd_pkg::cfg_t                   cfg
);

    pmd_pkg::cfg_t cfg_reg;
    pmd_pkg::cfg_t cfg_next;
    logic [2:0]    index;
    logic          write_en;

    assign index    = paddr[4:2];
    assign pready   = 1'b1;
    assign write_en = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (write_en) begin
            unique case (index)
                pmd_pkg::REG_GAIN_PROP:  cfg_next.gain_prop  = pwdata[15:0];
                pmd_pkg::REG_GAIN_INTEG: cfg_next.gain_integ = pwdata[15:0];
                pmd_pkg::REG_GAIN_DERIV: cfg_next.gain_deriv = pwdata[15:0];
                pmd_pkg::REG_LIMIT_LOW:  cfg_next.limit_low  = pwdata[15:0];
                pmd_pkg::REG_LIMIT_HIGH: cfg_next.limit_high = pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            pmd_pkg::REG_GAIN_PROP:  prdata = 32'($signed(cfg_reg.gain_prop));
            pmd_pkg::REG_GAIN_INTEG: prdata = 32'($signed(cfg_reg.gain_integ));
            pmd_pkg::REG_GAIN_DERIV: prdata = 32'($signed(cfg_reg.gain_deriv));
            pmd_pkg::REG_LIMIT_LOW:  prdata = 32'($signed(cfg_reg.limit_low));
            pmd_pkg::REG_LIMIT_HIGH: prdata = {17'b0, cfg_reg.limit_high};
            default:                 prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop  <= '0;
            cfg_reg.gain_integ <= '0;
            cfg_reg.gain_deriv <= '0;
            cfg_reg.limit_low  <= '0;
            cfg_reg.limit_high <= pmd_pkg::LIMIT_HIGH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pmd_integ_stage.sv]
// Sample register, error terms, gain products and clamped integral state
`default_nettype none

module pmd_integ_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pmd_pkg::cfg_t              cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [pmd_pkg::DATA_W-1:0] in_measured,
    input  wire logic [pmd_pkg::DATA_W-1:0] in_setpoint,
    input  wire logic                       in_clear,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output pmd_pkg::stage_t                 out_data
);

    logic                        valid_reg;
    logic [pmd_pkg::DATA_W-1:0]  measured_reg;
    logic [pmd_pkg::DATA_W-1:0]  setpoint_reg;
    logic                        clear_reg;
    logic [pmd_pkg::DATA_W-1:0]  prev_meas_reg;
    logic [pmd_pkg::INTEG_W-1:0] integ_reg;
    logic [pmd_pkg::INTEG_W-1:0] integ_next;
    logic                        advance;

    logic signed [16:0] err;
    logic signed [16:0] d_meas;
    logic signed [32:0] prod_integ;
    logic signed [32:0] prod_prop;
    logic signed [32:0] prod_deriv;
    logic signed [33:0] integ_base;
    logic signed [33:0] integ_sum;
    logic signed [33:0] hi_q;
    logic signed [33:0] lo_q;
    logic signed [33:0] integ_hi;
    logic signed [33:0] integ_clamped;

    assign advance   = valid_reg && out_ready;
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        err        = 17'($signed(setpoint_reg)) - 17'($signed(measured_reg));
        d_meas     = 17'($signed(measured_reg)) - 17'($signed(prev_meas_reg));
        prod_integ = 33'($signed(cfg.gain_integ)) * 33'(err);
        prod_prop  = 33'($signed(cfg.gain_prop)) * 33'(err);
        prod_deriv = 33'($signed(cfg.gain_deriv)) * 33'(d_meas);

        integ_base = clear_reg ? 34'sd0 : 34'($signed(integ_reg));
        integ_sum  = integ_base + 34'(prod_integ);
        hi_q       = 34'($signed({1'b0, cfg.limit_high, 8'b0}));
        lo_q       = 34'($signed({cfg.limit_low, 8'b0}));
        integ_hi      = (integ_sum > hi_q) ? hi_q : integ_sum;
        integ_clamped = (integ_hi < lo_q) ? lo_q : integ_hi;
        integ_next    = integ_clamped[pmd_pkg::INTEG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            integ_reg     <= '0;
            prev_meas_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (advance) begin
                integ_reg     <= integ_next;
                prev_meas_reg <= measured_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            measured_reg <= in_measured;
            setpoint_reg <= in_setpoint;
            clear_reg    <= in_clear;
        end
    end

    assign out_data.integ      = integ_next;
    assign out_data.prop_term  = prod_prop;
    assign out_data.deriv_term = prod_deriv;

endmodule

`default_nettype wire

[rtl/pmd_output_stage.sv]
// Sum of terms, magnitude, drive clamp and result register
`default_nettype none

module pmd_output_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [pmd_pkg::LIMIT_W-1:0] limit_high,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire pmd_pkg::stage_t             in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pmd_pkg::LIMIT_W-1:0]      out_level,
    output logic                             out_reverse
);

    pmd_pkg::stage_t             term_reg;
    logic                        term_valid_reg;
    logic                        term_ready;
    logic                        res_valid_reg;
    logic [pmd_pkg::LIMIT_W-1:0] level_reg;
    logic                        reverse_reg;
    logic [pmd_pkg::LIMIT_W-1:0] level_next;
    logic                        reverse_next;
    logic signed [34:0]          total;
    logic [34:0]                 mag;
    logic [26:0]                 level_full;

    assign term_ready = !res_valid_reg || out_ready;
    assign in_ready   = !term_valid_reg || term_ready;

    always_comb begin
        total = 35'($signed(term_reg.integ)) + 35'($signed(term_reg.prop_term))
              - 35'($signed(term_reg.deriv_term));
        mag          = total[34] ? 35'(-total) : 35'(total);
        level_full   = mag[34:8];
        reverse_next = total[34];
        level_next   = (level_full > 27'(limit_high)) ? limit_high
                                                      : level_full[pmd_pkg::LIMIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                term_valid_reg <= in_valid;
            end
            if (term_ready) begin
                res_valid_reg <= term_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            term_reg <= in_data;
        end
        if (term_valid_reg && term_ready) begin
            level_reg   <= level_next;
            reverse_reg <= reverse_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_level   = level_reg;
    assign out_reverse = reverse_reg;

endmodule

`default_nettype wire

[rtl/pid_motor_drive_core.sv]
// Top level of the PID motor drive core
// Use: one control sample goes in on the s_ stream per transfer (measured and
// setpoint in s_tdata, the integral clear flag in s_tuser); one result comes out
// on the m_ stream per sample, in order (drive level and direction in m_tdata).
// Gains and limits sit in APB registers at byte addresses 0x00 to 0x10; write
// them only while no sample is in flight.
// Path: a sample taken into the input register passes the term register, then
// the result register, before its result shows on m_tvalid.
// Throughput: one sample per cycle unless m_tready stalls; the integral update
// closes its loop via a single 16x17 multiply, add and clamp in the first stage.
// Reset: clears the integral, the previous measurement and all valid flags,
// sets the gains and lower limit to zero and the upper limit to 255.
// Stall: a held m_tready keeps the result; each stage takes a new transfer
// while the stage after it is empty or moving, so s_tready falls only once
// every stage holds a sample.
`default_nettype none

module pid_motor_drive_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,  // measured[15:0], setpoint[31:16]
    input  wire logic                       s_tuser,  // clear_integral[0]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [15:0]                m_tdata,  // drive_level[14:0], reverse[15]
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pmd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    pmd_pkg::cfg_t               cfg;
    pmd_pkg::stage_t             terms;
    logic                        terms_valid;
    logic                        terms_ready;
    logic [pmd_pkg::LIMIT_W-1:0] drive_level;
    logic                        reverse;

    pmd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pmd_integ_stage u_integ (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_measured (s_tdata[15:0]),
        .in_setpoint (s_tdata[31:16]),
        .in_clear    (s_tuser),
        .out_valid   (terms_valid),
        .out_ready   (terms_ready),
        .out_data    (terms)
    );

    pmd_output_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .limit_high  (cfg.limit_high),
        .in_valid    (terms_valid),
        .in_ready    (terms_ready),
        .in_data     (terms),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_level   (drive_level),
        .out_reverse (reverse)
    );

    assign m_tdata = {reverse, drive_level};

`include "pid_motor_drive_core_assert.svh"

    `PMD_ASSERT_NOW(a_ready_when_empty, !m_tvalid && !terms_valid, s_tready, "input blocked with empty pipeline")
    `PMD_ASSERT_NOW(a_block_when_full, m_tvalid && !m_tready && terms_valid && u_integ.out_valid && !terms_ready, terms_ready == 1'b0, "stall not held")
    `PMD_ASSERT_LATER(a_empty_pipe_latency, s_tvalid && s_tready && !terms_valid && !m_tvalid && !u_integ.out_valid, terms_valid, "transfer lost in first stage")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking stream and register testbench for the PID motor drive core
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;

    typedef struct packed {
        logic [15:0] meas;
        logic [15:0] tgt;
        logic        clr;
    } sample_t;

    typedef struct packed {
        logic [14:0] level;
        logic        rev;
    } drive_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [31:0]                s_tdata  = '0;  // measured[15:0], setpoint[31:16]
    logic                       s_tuser  = 1'b0;  // clear_integral[0]
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [15:0]                m_tdata;  // drive_level[14:0], reverse[15]
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [pmd_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                pwdata   = '0;
    logic [31:0]                prdata;
    logic                       pready;

    pid_motor_drive_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // controller copy: gains, limits and state
    logic signed [15:0] g_prop  = '0;
    logic signed [15:0] g_integ = '0;
    logic signed [15:0] g_deriv = '0;
    logic signed [15:0] lim_lo  = '0;
    logic [14:0]        lim_hi  = pmd_pkg::LIMIT_HIGH_RESET;
    longint             integ_acc = 0;
    logic signed [15:0] last_meas = '0;

    sample_t sample_queue[$];
    drive_t  drive_expect[$];
    sample_t tx_item;
    drive_t  rx_got;
    drive_t  rx_want;
    int      issued    = 0;
    int      accepted  = 0;
    int      errors    = 0;
    int      tx_wait   = 0;
    int      rx_wait   = 0;
    bit      tx_gaps   = 1'b0;
    bit      rx_gaps   = 1'b0;
    bit      stall_req = 1'b0;
    bit      stall_done = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic drive_t pid_step(logic signed [15:0] meas, logic signed [15:0] tgt,
                                        logic clr);
        longint err;
        longint dmeas;
        longint hi_q;
        longint lo_q;
        longint raw;
        longint mag;
        longint lvl;
        drive_t r;
        hi_q = longint'(lim_hi) * 256;
        lo_q = longint'(lim_lo) * 256;
        if (clr) integ_acc = 0;
        err   = longint'(tgt) - longint'(meas);
        dmeas = longint'(meas) - longint'(last_meas);
        integ_acc = integ_acc + longint'(g_integ) * err;
        // upper clamp first, so crossed limits settle on the lower one
        if (integ_acc > hi_q) integ_acc = hi_q;
        if (integ_acc < lo_q) integ_acc = lo_q;
        raw = integ_acc + longint'(g_prop) * err - longint'(g_deriv) * dmeas;
        mag = (raw < 0) ? -raw : raw;
        lvl = mag >>> 8;
        if (lvl > longint'(lim_hi)) lvl = longint'(lim_hi);
        r.level = lvl[14:0];
        r.rev   = (raw < 0);
        last_meas = meas;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                drive_expect.push_back(pid_step(s_tdata[15:0], s_tdata[31:16], s_tuser));
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    tx_item = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_item.tgt, tx_item.meas};
                    s_tuser  <= tx_item.clr;
                    if (tx_gaps) tx_wait = gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_got.level = m_tdata[14:0];
                rx_got.rev   = m_tdata[15];
                if (drive_expect.size() == 0) begin
                    $error("unexpected result: drive_level %0d reverse %0d",
                           rx_got.level, rx_got.rev);
                    errors++;
                end else begin
                    rx_want = drive_expect.pop_front();
                    if (rx_got.level !== rx_want.level) begin
                        $error("drive_level: expected %0d, actual %0d",
                               rx_want.level, rx_got.level);
                        errors++;
                    end
                    if (rx_got.rev !== rx_want.rev) begin
                        $error("reverse: expected %0d, actual %0d", rx_want.rev, rx_got.rev);
                        errors++;
                    end
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else if (stall_req && !stall_done) begin
                // hold off long enough for every stage to fill
                stall_done <= 1'b1;
                rx_wait = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                rx_wait = gap_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pmd_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pmd_pkg::REG_GAIN_PROP:  g_prop  = val[15:0];
            pmd_pkg::REG_GAIN_INTEG: g_integ = val[15:0];
            pmd_pkg::REG_GAIN_DERIV: g_deriv = val[15:0];
            pmd_pkg::REG_LIMIT_LOW:  lim_lo  = val[15:0];
            pmd_pkg::REG_LIMIT_HIGH: lim_hi  = val[14:0];
            default: ;
        endcase
    endtask

    // junk in the upper bits must be dropped by the block
    task automatic cfg_all(input logic [15:0] gp, input logic [15:0] gi, input logic [15:0] gd,
                           input logic [15:0] lo, input logic [15:0] hi);
        logic [31:0] junk;
        junk = $urandom();
        reg_write(pmd_pkg::REG_GAIN_PROP,  {junk[31:16], gp});
        reg_write(pmd_pkg::REG_GAIN_INTEG, {junk[15:0], gi});
        reg_write(pmd_pkg::REG_GAIN_DERIV, {~junk[31:16], gd});
        reg_write(pmd_pkg::REG_LIMIT_LOW,  {~junk[15:0], lo});
        reg_write(pmd_pkg::REG_LIMIT_HIGH, {junk[23:8], hi});
        reg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
    endtask

    task automatic push_sample(input logic [15:0] meas, input logic [15:0] tgt, input logic clr);
        sample_t s;
        s.meas = meas;
        s.tgt  = tgt;
        s.clr  = clr;
        sample_queue.push_back(s);
        issued++;
    endtask

    task automatic settle();
        while (!(sample_queue.size() == 0 && accepted == issued && drive_expect.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4, 5, 6: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] cur_meas;
        logic [15:0] cur_tgt;
        logic [15:0] hi_val;
        int r;
        cur_meas = '0;
        cur_tgt  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cfg_all(16'h0100, 16'h0040, 16'h0080, -16'sd1000, 16'd2000);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // first sample is taken against a previous measurement of zero
        push_sample(16'd1234, 16'd1300, 1'b0);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h7FFF, 16'h7FFF, 1'b1);
        push_sample(16'h0000, 16'h0000, 1'b0);
        push_sample(16'd100, 16'd50, 1'b1);
        push_sample(16'd100, 16'd50, 1'b0);
        settle();

        // crossed limits
        cfg_all(16'h0100, 16'h0100, 16'h0000, 16'd500, 16'd100);
        push_sample(16'd0, 16'd10, 1'b0);
        push_sample(16'd0, -16'sd10, 1'b1);
        push_sample(16'd5, 16'd5, 1'b0);
        settle();

        cfg_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h0000, 16'h0000, 1'b1);
        push_sample(16'h0001, 16'hFFFF, 1'b0);
        settle();

        cfg_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
        push_sample(16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 1'b1);
        push_sample(16'h1234, 16'h1234, 1'b0);
        push_sample(16'hFFFF, 16'h0000, 1'b0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            r = $urandom_range(0, 5);
            hi_val = (r == 0) ? 16'h0000 : (r == 1) ? 16'h7FFF :
                     (r < 4) ? 16'($urandom_range(1, 4000)) : 16'($urandom());
            r = $urandom_range(0, 5);
            cfg_all(pick_gain(), pick_gain(), pick_gain(),
                    (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF :
                    (r < 4) ? -16'($urandom_range(0, 4000)) : 16'($urandom()),
                    hi_val);
            tx_gaps = (ph % 4 != 1) && (ph != 3);
            rx_gaps = (ph % 4 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    push_sample(16'($urandom()), 16'($urandom()), 1'($urandom()));
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        cur_tgt = 16'($urandom());
                        push_sample(cur_meas, cur_tgt, 1'b1);
                    end else begin
                        cur_meas = cur_meas + 16'($urandom_range(0, 64)) - 16'd32;
                        push_sample(cur_meas, cur_tgt, 1'b0);
                    end
                end
            end
            if (ph == 3) stall_req = 1'b1;
            settle();
        end

        repeat (10) @(posedge aclk);
        if (drive_expect.size() != 0) begin
            $error("drive results still expected: %0d", drive_expect.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pmd_pkg.sv
rtl/pmd_cfg_regs.sv
rtl/pmd_integ_stage.sv
rtl/pmd_output_stage.sv
rtl/pid_motor_drive_core.sv
tb/tb_top.sv
